// File: hdl/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and constants of the palette fade engine.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int PFE_ENTRIES_DEF    = 64;
	localparam int PFE_FADE_TICKS_DEF = 21;

	localparam logic [7:0] STEP_VAL  = 8'd32;
	localparam logic [7:0] WHITE_VAL = 8'd224;

	// request kinds
	localparam logic [2:0] KIND_WR_TARGET = 3'd0;
	localparam logic [2:0] KIND_WR_WORK   = 3'd1;
	localparam logic [2:0] KIND_START     = 3'd2;
	localparam logic [2:0] KIND_TICK      = 3'd3;
	localparam logic [2:0] KIND_READ      = 3'd4;

	// fade modes
	localparam logic [2:0] MODE_NONE      = 3'd0;
	localparam logic [2:0] MODE_FADE_IN   = 3'd1;
	localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
	localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
	localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

	// config register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ENTRY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_BANK = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic       bank;
		logic [5:0] index;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [2:0] mode;
	} item_t;

	typedef struct packed {
		logic       done_res;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic wr_item;
		logic set_mode;
		logic tick_upd;
		logic load_range;
		logic next_bank;
		logic advance;
		logic fill_wr;
		logic walk_rd;
		logic latch_rd;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] kind;
		logic       start_fill;
		logic       active_none;
		logic       range_empty;
		logic       ent_last;
		logic       bank_is0;
		logic       bank1_skip;
	} status_t;

endpackage

// File: hdl/pfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/pfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module pfe_ctrl import pfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_FILL   = 3'd2;
	localparam logic [2:0] S_WALK   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_RDWAIT = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.kind)
					KIND_WR_TARGET, KIND_WR_WORK: begin
						cmd.wr_item = 1'b1;
						state_d     = S_RESP;
					end
					KIND_START: begin
						cmd.set_mode   = 1'b1;
						cmd.load_range = 1'b1;
						state_d = (status.start_fill && !status.range_empty) ? S_FILL : S_RESP;
					end
					KIND_TICK: begin
						cmd.tick_upd   = 1'b1;
						cmd.load_range = 1'b1;
						state_d = (status.active_none || status.range_empty) ? S_RESP : S_WALK;
					end
					KIND_READ: begin
						state_d = S_RDWAIT;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				cmd.advance = !status.ent_last;
				if (status.ent_last) begin
					state_d = S_RESP;
				end
			end
			S_WALK: begin
				cmd.walk_rd = 1'b1;
				if (!status.ent_last) begin
					cmd.advance = 1'b1;
				end else if (status.bank_is0 && !status.bank1_skip) begin
					cmd.next_bank = 1'b1;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: state_d = S_RESP;
			S_RDWAIT: begin
				cmd.latch_rd = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: hdl/pfe_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_dpath
// Palette memories, config, fade state, entry walker and step logic.
// ----------------------------------------------------------------------------
module pfe_dpath import pfe_pkg::*; #(
	parameter int PALETTE_ENTRIES = PFE_ENTRIES_DEF,
	parameter int FADE_TICKS      = PFE_FADE_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output status_t               status,
	output logic                  res_valid,
	output result_t               result
);

	localparam int EW    = $clog2(PALETTE_ENTRIES);
	localparam int DEPTH = 2 * PALETTE_ENTRIES;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = ((EW > 6) ? EW : 6) + 1;
	localparam int TW    = $clog2(FADE_TICKS + 1);

	typedef logic [EW-1:0] ent_t;
	typedef logic [AW-1:0] addr_t;

	function automatic addr_t addr_of(input logic b, input ent_t e);
		return b ? (AW'(PALETTE_ENTRIES) + AW'(e)) : AW'(e);
	endfunction

	// one channel step for the active mode; channels packed red, green, blue
	function automatic logic [23:0] step_entry(input logic [2:0] m,
	                                          input logic [23:0] w,
	                                          input logic [23:0] t);
		logic [7:0] wr, wg, wb, tr, tg, tb;
		logic [23:0] r;
		wr = w[23:16]; wg = w[15:8]; wb = w[7:0];
		tr = t[23:16]; tg = t[15:8]; tb = t[7:0];
		r  = w;
		priority case (m)
			MODE_FADE_IN: begin
				priority if (tb > wb) r[7:0]   = wb + STEP_VAL;
				else if (tg > wg)     r[15:8]  = wg + STEP_VAL;
				else if (tr > wr)     r[23:16] = wr + STEP_VAL;
				else                  r        = w;
			end
			MODE_FLASH_IN: begin
				priority if (tb < wb) r[7:0]   = wb - STEP_VAL;
				else if (tg < wg)     r[15:8]  = wg - STEP_VAL;
				else if (tr < wr)     r[23:16] = wr - STEP_VAL;
				else                  r        = w;
			end
			MODE_FADE_OUT: begin
				priority if (wr != 8'd0) r[23:16] = wr - STEP_VAL;
				else if (wg != 8'd0)     r[15:8]  = wg - STEP_VAL;
				else if (wb != 8'd0)     r[7:0]   = wb - STEP_VAL;
				else                     r        = w;
			end
			default: begin
				priority if (wr != WHITE_VAL) r[23:16] = wr + STEP_VAL;
				else if (wg != WHITE_VAL)     r[15:8]  = wg + STEP_VAL;
				else if (wb != WHITE_VAL)     r[7:0]   = wb + STEP_VAL;
				else                          r        = w;
			end
		endcase
		return r;
	endfunction

	item_t           item_q;
	logic [5:0]      start_entry_q, last_offset_q;
	logic            single_bank_q;
	logic [2:0]      active_mode_q;
	logic [TW-1:0]   tick_cnt_q;
	ent_t            ent_q;
	logic            bank_q;
	logic            wb_en_s1;
	addr_t           wb_addr_s1;
	result_t         res_q;
	logic            res_valid_q;

	logic            range_fade_in, range_empty, idx_ok;
	logic [RW-1:0]   first_full, sum_full, last_cap, last_full;
	ent_t            first_e, last_e, item_ent;
	logic [2:0]      new_mode;
	addr_t           item_addr, walk_addr;
	logic            w_we, t_we;
	addr_t           w_waddr, w_raddr;
	logic [23:0]     w_wdata, w_rdata, t_rdata, fill_rgb, item_rgb;

	// range: fade-in uses the config window clipped at the last entry
	assign range_fade_in = (item_q.kind == KIND_START) ? (item_q.mode == MODE_FADE_IN)
	                                                    : (active_mode_q == MODE_FADE_IN);
	assign first_full  = range_fade_in ? RW'(start_entry_q) : '0;
	assign sum_full    = RW'(start_entry_q) + RW'(last_offset_q);
	assign last_cap    = RW'(PALETTE_ENTRIES - 1);
	assign last_full   = (range_fade_in && (sum_full < last_cap)) ? sum_full : last_cap;
	assign range_empty = (first_full > last_full);
	assign first_e     = first_full[EW-1:0];
	assign last_e      = last_full[EW-1:0];

	assign idx_ok    = (RW'(item_q.index) < RW'(PALETTE_ENTRIES));
	assign item_ent  = EW'(item_q.index);
	assign item_addr = addr_of(item_q.bank, item_ent);
	assign walk_addr = addr_of(bank_q, ent_q);

	assign new_mode = ((item_q.mode >= MODE_FADE_IN) && (item_q.mode <= MODE_FLASH_OUT))
	                  ? item_q.mode : MODE_NONE;

	assign fill_rgb = (item_q.mode == MODE_FADE_IN) ? 24'd0 : {3{WHITE_VAL}};
	assign item_rgb = {item_q.red_in, item_q.green_in, item_q.blue_in};

	always_comb begin
		w_we    = 1'b0;
		w_waddr = item_addr;
		w_wdata = item_rgb;
		priority if (wb_en_s1) begin
			w_we    = 1'b1;
			w_waddr = wb_addr_s1;
			w_wdata = step_entry(active_mode_q, w_rdata, t_rdata);
		end else if (cmd.fill_wr) begin
			w_we    = 1'b1;
			w_waddr = addr_of(1'b0, ent_q);
			w_wdata = fill_rgb;
		end else if (cmd.wr_item && (item_q.kind == KIND_WR_WORK) && idx_ok) begin
			w_we = 1'b1;
		end else begin
			w_we = 1'b0;
		end
	end

	assign t_we    = cmd.wr_item && (item_q.kind == KIND_WR_TARGET) && idx_ok;
	assign w_raddr = cmd.walk_rd ? walk_addr : item_addr;

	pfe_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_work_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	pfe_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_target_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (item_addr),
		.wdata (item_rgb),
		.raddr (walk_addr),
		.rdata (t_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_entry_q <= '0;
			last_offset_q <= 6'd63;
			single_bank_q <= 1'b0;
			active_mode_q <= MODE_NONE;
			tick_cnt_q    <= '0;
			wb_en_s1      <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_ENTRY: start_entry_q <= cfg_data;
					CFG_LAST_OFFSET: last_offset_q <= cfg_data;
					CFG_SINGLE_BANK: single_bank_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.set_mode) begin
				active_mode_q <= new_mode;
				tick_cnt_q    <= '0;
			end
			if (cmd.tick_upd && (active_mode_q != MODE_NONE)) begin
				tick_cnt_q <= (tick_cnt_q == TW'(FADE_TICKS)) ? '0 : tick_cnt_q + 1'b1;
			end
			wb_en_s1    <= cmd.walk_rd;
			res_valid_q <= cmd.emit;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			res_q  <= '0;
		end
		if (cmd.tick_upd) begin
			res_q.done_res <= (active_mode_q == MODE_NONE) ||
			                  (tick_cnt_q == TW'(FADE_TICKS));
		end
		if (cmd.latch_rd && idx_ok) begin
			res_q.red_out   <= w_rdata[23:16];
			res_q.green_out <= w_rdata[15:8];
			res_q.blue_out  <= w_rdata[7:0];
		end
		if (cmd.load_range || cmd.next_bank) begin
			ent_q <= first_e;
		end else if (cmd.advance) begin
			ent_q <= ent_q + 1'b1;
		end
		if (cmd.load_range) begin
			bank_q <= 1'b0;
		end else if (cmd.next_bank) begin
			bank_q <= 1'b1;
		end
		wb_addr_s1 <= walk_addr;
	end

	assign status.kind        = item_q.kind;
	assign status.start_fill  = (item_q.mode == MODE_FADE_IN) || (item_q.mode == MODE_FLASH_IN);
	assign status.active_none = (active_mode_q == MODE_NONE);
	assign status.range_empty = range_empty;
	assign status.ent_last    = (ent_q == last_e);
	assign status.bank_is0    = !bank_q;
	assign status.bank1_skip  = single_bank_q && ((active_mode_q == MODE_FADE_IN) ||
	                                              (active_mode_q == MODE_FLASH_IN));

	assign res_valid = res_valid_q;
	assign result    = res_q;

endmodule

// File: hdl/palette_fade_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_engine_core
// Two-bank working/target RGB palette with per-frame fade and flash steps.
// ----------------------------------------------------------------------------
// Accept to result strobe: a write decodes and responds; a read adds a read
//   wait; start may add a bank 0 fill of the range; tick responds at once
//   with no fade or an empty range, else drains after walking the entries
//   (one entry per cycle through the working RAM read/write ports, up to
//   2 x PALETTE_ENTRIES). One request at a time; the next start is taken
//   in the strobe cycle.
// Reset: async active low; sequencer idle, no fade active, tick count zero,
//   config at start_entry 0, last_offset 63, single_bank 0. Palette RAMs are
//   not cleared. Results cannot be stalled: each is shown for one cycle.
// ----------------------------------------------------------------------------
module palette_fade_engine_core import pfe_pkg::*; #(
	parameter int PALETTE_ENTRIES = PFE_ENTRIES_DEF,
	parameter int FADE_TICKS      = PFE_FADE_TICKS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	// result channel
	output logic                  res_valid,
	output result_t               result,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Sequencer: decode, then fill / walk / read as the request needs.
	pfe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// Datapath: palette RAMs, config registers, fade state and step logic.
	// A tick walk reads entry n while the stepped value of entry n-1 is
	// written back, so the walk handles one entry per cycle, then drains.
	pfe_dpath #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES),
		.FADE_TICKS      (FADE_TICKS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.res_valid (res_valid),
		.result    (result)
	);

	// accepted request makes the engine busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but engine not busy");

	// result strobe lands in the idle cycle after the response state
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !busy)
		else $error("result strobe while busy");

	// one result per request: the strobe is never asserted back to back
	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("result strobe held for more than one cycle");

	// no fill or item write may collide with the write-back of a walked entry
	a_wb_follows_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_rd |=> !cmd.fill_wr && !cmd.wr_item)
		else $error("palette write collides with walk write-back");

endmodule
